### design/life_automaton_generation_top_assert.svh
// Assertion macros for the life automaton generation block.
// Needs a clk and an active-low arst_n in the scope where a macro is used.
`ifndef LIFE_AUTOMATON_GENERATION_TOP_ASSERT_SVH
`define LIFE_AUTOMATON_GENERATION_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LIFEGEN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define LIFEGEN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/lifegen_pkg.sv
// Shared types, codes and the B3/S23 cell rule for the life automaton block.
// No dependencies; used by life_automaton_generation_top.
`default_nettype none

package lifegen_pkg;

	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] GRID_RESET = 7'd10;

	// configuration register indexes
	localparam logic [0:0] REG_GRID_ROWS = 1'b0;
	localparam logic [0:0] REG_GRID_COLS = 1'b1;

	// request kinds
	localparam logic [1:0] KIND_WRITE   = 2'd0;
	localparam logic [1:0] KIND_ADVANCE = 2'd1;
	localparam logic [1:0] KIND_READ    = 2'd2;

	// neighbor counts of the rule
	localparam logic [3:0] LIVE_BIRTH = 4'd3;
	localparam logic [3:0] LIVE_KEEP  = 4'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_ADV_LOAD,
		ST_ADV_RUN
	} state_t;

	// Next value of one cell from its eight neighbors and itself.
	function automatic logic life_rule(input logic [7:0] nb, input logic self);
		logic [3:0] n;
		n = '0;
		for (int k = 0; k < 8; k++) begin
			n = n + {3'b000, nb[k]};
		end
		return (n == LIVE_BIRTH) || ((n == LIVE_KEEP) && self);
	endfunction

endpackage

`default_nettype wire

### design/life_automaton_generation_top.sv
// Top level of the life automaton block: two-bank row memory, sequencer and ports.
// Depends on lifegen_pkg and life_automaton_generation_top_assert.svh.
//
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_ready    kind, row, col, value
// out       out  out_valid / out_ready  cell_alive, in_range
// cfg       in   cfg_we                 cfg_index, cfg_wdata
//
// A cell write reads the row while idle and writes it back in ST_WRITE; a read reads it
// while idle, then waits in ST_READ for the output register to drain.
// An advance reads row 0 while idle and row 1 in ST_ADV_LOAD, then one memory row per
// cycle in ST_ADV_RUN, with a window of three rows feeding MAX_COLS cell lanes.
// After reset the block sweeps every row of bank 0 to dead with in_ready low.
// The memory port pair (one read, one write per cycle) sets the advance rate.
`default_nettype none

module life_automaton_generation_top
	import lifegen_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       kind,
	input  wire logic [5:0]       row,
	input  wire logic [5:0]       col,
	input  wire logic             value,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  cell_alive,
	output logic                  in_range,
	input  wire logic             cfg_we,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int RCNT_W    = $clog2(MAX_ROWS + 1);
	localparam int CCNT_W    = $clog2(MAX_COLS + 1);
	localparam int ADDR_W    = ROW_W + 1;
	localparam int MEM_DEPTH = 2 ** ADDR_W;

	state_t state_q, state_nx;

	logic [CFG_W-1:0]    grid_rows_q, grid_cols_q;
	logic                bank_q;
	logic [ROW_W-1:0]    ctr_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic                value_q;
	logic                inside_q;
	logic [MAX_COLS-1:0] above_q, center_q;
	logic                out_valid_q, cell_alive_q, in_range_q;

	logic [MAX_COLS-1:0] mem [MEM_DEPTH];
	logic [MAX_COLS-1:0] rd_row_s1;

	logic                mem_re, mem_we;
	logic [ADDR_W-1:0]   mem_raddr, mem_waddr;
	logic [MAX_COLS-1:0] mem_wdata;
	logic                out_load;

	logic [RCNT_W-1:0]   eff_rows;
	logic [CCNT_W-1:0]   eff_cols;
	logic                inside_in;
	logic                ctr_last;
	logic                cur_ok, below_ok, first_ok;
	logic [MAX_COLS-1:0] col_mask;
	logic [MAX_COLS-1:0] below;
	logic [MAX_COLS-1:0] patched_row;
	logic [MAX_COLS-1:0] life_row;
	logic [MAX_COLS-1:0] a_lo, a_hi, c_lo, c_hi, b_lo, b_hi;

	// clamp the configured size to the storage size
	always_comb begin
		if (32'(grid_rows_q) > 32'(MAX_ROWS)) begin
			eff_rows = RCNT_W'(MAX_ROWS);
		end else begin
			eff_rows = RCNT_W'(grid_rows_q);
		end
		if (32'(grid_cols_q) > 32'(MAX_COLS)) begin
			eff_cols = CCNT_W'(MAX_COLS);
		end else begin
			eff_cols = CCNT_W'(grid_cols_q);
		end
	end

	assign inside_in = (32'(row) < 32'(eff_rows)) && (32'(col) < 32'(eff_cols));
	assign ctr_last  = (ctr_q == ROW_W'(MAX_ROWS - 1));
	assign cur_ok    = 32'(ctr_q) < 32'(eff_rows);
	assign below_ok  = (32'(ctr_q) + 32'd1) < 32'(eff_rows);
	assign first_ok  = (eff_rows != '0);

	always_comb begin
		for (int j = 0; j < MAX_COLS; j++) begin
			col_mask[j] = 32'(j) < 32'(eff_cols);
		end
	end

	// cells beyond the grid in use count as dead
	assign below = rd_row_s1 & col_mask & {MAX_COLS{below_ok}};

	assign a_lo = above_q << 1;
	assign a_hi = above_q >> 1;
	assign c_lo = center_q << 1;
	assign c_hi = center_q >> 1;
	assign b_lo = below << 1;
	assign b_hi = below >> 1;

	always_comb begin
		for (int j = 0; j < MAX_COLS; j++) begin
			life_row[j] = life_rule({a_lo[j], above_q[j], a_hi[j], c_lo[j], c_hi[j],
				b_lo[j], below[j], b_hi[j]}, center_q[j]) & col_mask[j] & cur_ok;
		end
	end

	always_comb begin
		patched_row         = rd_row_s1;
		patched_row[col_q]  = value_q;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (ctr_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (kind)
						KIND_WRITE:   state_nx = inside_in ? ST_WRITE : ST_IDLE;
						KIND_ADVANCE: state_nx = ST_ADV_LOAD;
						KIND_READ:    state_nx = ST_READ;
						default:      state_nx = ST_IDLE;
					endcase
				end
			end
			ST_WRITE:    state_nx = ST_IDLE;
			ST_READ: begin
				if (out_load) state_nx = ST_IDLE;
			end
			ST_ADV_LOAD: state_nx = ST_ADV_RUN;
			ST_ADV_RUN: begin
				if (ctr_last) state_nx = ST_IDLE;
			end
			default:     state_nx = ST_IDLE;
		endcase
	end

	// memory and handshake controls
	always_comb begin
		in_ready  = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_raddr = {bank_q, ROW_W'(row)};
		mem_waddr = {bank_q, ctr_q};
		mem_wdata = '0;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = {1'b0, ctr_q};
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (kind == KIND_ADVANCE) begin
					mem_raddr = {bank_q, {ROW_W{1'b0}}};
				end
				mem_re = in_valid && ((kind == KIND_READ) || (kind == KIND_ADVANCE) ||
					((kind == KIND_WRITE) && inside_in));
			end
			ST_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = {bank_q, row_q};
				mem_wdata = patched_row;
			end
			ST_READ: begin
				out_load = !out_valid_q || out_ready;
			end
			ST_ADV_LOAD: begin
				mem_re    = 1'b1;
				mem_raddr = {bank_q, ROW_W'(1)};
			end
			ST_ADV_RUN: begin
				mem_re    = 1'b1;
				mem_raddr = {bank_q, ROW_W'(32'(ctr_q) + 32'd2)};
				mem_we    = 1'b1;
				mem_waddr = {~bank_q, ctr_q};
				mem_wdata = life_row;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// row memory, one read and one write port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_row_s1 <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			ctr_q       <= '0;
			bank_q      <= 1'b0;
			grid_rows_q <= GRID_RESET;
			grid_cols_q <= GRID_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID_ROWS: grid_rows_q <= cfg_wdata;
					REG_GRID_COLS: grid_cols_q <= cfg_wdata;
					default:       grid_rows_q <= grid_rows_q;
				endcase
			end
			if ((state_q == ST_CLEAR) || (state_q == ST_ADV_RUN)) begin
				ctr_q <= ctr_last ? '0 : ctr_q + ROW_W'(1);
			end
			// swap banks once the last row is written
			if ((state_q == ST_ADV_RUN) && ctr_last) begin
				bank_q <= ~bank_q;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			row_q    <= ROW_W'(row);
			col_q    <= COL_W'(col);
			value_q  <= value;
			inside_q <= inside_in;
		end
		if (out_load) begin
			cell_alive_q <= inside_q & rd_row_s1[col_q];
			in_range_q   <= inside_q;
		end
		// slide the three-row window down the grid
		if (state_q == ST_ADV_LOAD) begin
			above_q  <= '0;
			center_q <= rd_row_s1 & col_mask & {MAX_COLS{first_ok}};
		end else if (state_q == ST_ADV_RUN) begin
			above_q  <= center_q;
			center_q <= below;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_alive = cell_alive_q;
	assign in_range   = in_range_q;

`include "life_automaton_generation_top_assert.svh"

	`LIFEGEN_ASSERT_NOW(a_ready_idle, in_ready, state_q == ST_IDLE, "request taken outside idle")
	`LIFEGEN_ASSERT_NOW(a_no_rw_clash, mem_re && mem_we, mem_raddr != mem_waddr, "read and write hit one row")
	`LIFEGEN_ASSERT_NOW(a_adv_other_bank, mem_we && (state_q == ST_ADV_RUN), mem_waddr[ROW_W] != bank_q, "advance wrote the live bank")
	`LIFEGEN_ASSERT_NEXT(a_bank_swap, (state_q == ST_ADV_RUN) && ctr_last, bank_q != $past(bank_q), "bank not swapped after advance")

endmodule

`default_nettype wire
